FILE: rtl/ppc_pkg.sv
// shared types, fragment table and codes for the path pattern classifier
// no dependencies
package ppc_pkg;

	localparam int IMAGE_PATH_CHARS = 512;
	localparam int REG_PATH_CHARS   = 512;
	localparam int WINDOW_DEPTH     = 46;
	localparam int FRAG_COUNT       = 12;
	localparam int FRAG_MAX         = WINDOW_DEPTH + 1;
	localparam int POS_W            = 10;
	localparam int LIMIT_W          = POS_W + 1;
	localparam int FRAG_LEN_W       = $clog2(FRAG_MAX + 1);

	localparam logic [LIMIT_W-1:0] IMAGE_LIMIT = LIMIT_W'(IMAGE_PATH_CHARS);
	localparam logic [LIMIT_W-1:0] REG_LIMIT   = LIMIT_W'(REG_PATH_CHARS);

	// path kinds
	localparam logic KIND_IMAGE = 1'b0;
	localparam logic KIND_REG   = 1'b1;

	// severity codes
	localparam logic [1:0] SEV_NONE = 2'd0;
	localparam logic [1:0] SEV_LOW  = 2'd1;
	localparam logic [1:0] SEV_MED  = 2'd2;
	localparam logic [1:0] SEV_HIGH = 2'd3;

	// rule codes
	localparam logic [2:0] RULE_NONE       = 3'd0;
	localparam logic [2:0] RULE_USER_IMAGE = 3'd1;
	localparam logic [2:0] RULE_SERVICE    = 3'd2;
	localparam logic [2:0] RULE_IFEO       = 3'd3;
	localparam logic [2:0] RULE_WINLOGON   = 3'd4;
	localparam logic [2:0] RULE_APPINIT    = 3'd5;
	localparam logic [2:0] RULE_AUTORUN    = 3'd6;

	// fragment indexes into the seen vector
	localparam int F_USERS     = 0;
	localparam int F_APPDATA   = 1;
	localparam int F_TEMP      = 2;
	localparam int F_SERVICES  = 3;
	localparam int F_RUN       = 4;
	localparam int F_IFEO      = 5;
	localparam int F_WINLOGON  = 6;
	localparam int F_APPINIT   = 7;
	localparam int F_IMAGEPATH = 8;
	localparam int F_DEBUGGER  = 9;
	localparam int F_SHELL     = 10;
	localparam int F_USERINIT  = 11;

	// fragment text right aligned: last character sits in bits [7:0]
	localparam logic [FRAG_MAX*8-1:0] FRAG_TEXT [FRAG_COUNT] = '{
		(FRAG_MAX*8)'("\\USERS\\"),
		(FRAG_MAX*8)'("\\APPDATA\\"),
		(FRAG_MAX*8)'("\\TEMP\\"),
		(FRAG_MAX*8)'("\\SYSTEM\\CURRENTCONTROLSET\\SERVICES\\"),
		(FRAG_MAX*8)'("\\CURRENTVERSION\\RUN"),
		(FRAG_MAX*8)'("\\IMAGE FILE EXECUTION OPTIONS\\"),
		(FRAG_MAX*8)'("\\WINLOGON\\"),
		(FRAG_MAX*8)'({"\\WINDOWS NT\\CURRENTVERSION\\WINDOWS\\APPINIT", "_DLLS"}),
		(FRAG_MAX*8)'("\\IMAGEPATH"),
		(FRAG_MAX*8)'("\\DEBUGGER"),
		(FRAG_MAX*8)'("\\SHELL"),
		(FRAG_MAX*8)'("\\USERINIT")
	};

	localparam logic [FRAG_LEN_W-1:0] FRAG_LEN [FRAG_COUNT] = '{
		FRAG_LEN_W'(7),  FRAG_LEN_W'(9),  FRAG_LEN_W'(6),  FRAG_LEN_W'(35),
		FRAG_LEN_W'(19), FRAG_LEN_W'(30), FRAG_LEN_W'(10), FRAG_LEN_W'(47),
		FRAG_LEN_W'(10), FRAG_LEN_W'(9),  FRAG_LEN_W'(6),  FRAG_LEN_W'(9)
	};

	typedef struct packed {
		logic        opcode;
		logic [15:0] path_char;
		logic        last;
	} item_t;

	typedef struct packed {
		logic       suspicious;
		logic [1:0] severity;
		logic [2:0] rule;
	} result_t;

	// path state as seen after the current item
	typedef struct packed {
		logic                  kind;
		logic [FRAG_COUNT-1:0] seen;
	} track_t;

	// upcase ascii letters, drop anything outside ascii to zero
	function automatic logic [7:0] fold_char(input logic [15:0] c);
		logic [7:0] r;
		begin
			if (c >= 16'h0080) begin
				r = 8'h00;
			end else if (c >= 16'h0061 && c <= 16'h007a) begin
				r = c[7:0] - 8'h20;
			end else begin
				r = c[7:0];
			end
			return r;
		end
	endfunction

endpackage

FILE: rtl/ppc_tracker.sv
// character window, fragment compare and per-path state
// depends on ppc_pkg
module ppc_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  ppc_pkg::item_t item,
	output ppc_pkg::track_t track
);

	logic [ppc_pkg::WINDOW_DEPTH*8-1:0] window_q;
	logic [ppc_pkg::FRAG_COUNT-1:0]     seen_q;
	logic [ppc_pkg::POS_W-1:0]          pos_q;
	logic                               term_q;
	logic                               kind_q;

	logic [7:0]                         cur;
	logic [ppc_pkg::FRAG_MAX*8-1:0]     span;
	logic [ppc_pkg::FRAG_COUNT-1:0]     hits;
	logic                               kind_eff;
	logic [ppc_pkg::LIMIT_W-1:0]        limit;
	logic [ppc_pkg::LIMIT_W-1:0]        pos_ext;
	logic [ppc_pkg::LIMIT_W-1:0]        pos_inc;
	logic                               in_range;
	logic                               active;
	logic                               term_next;
	logic [ppc_pkg::FRAG_COUNT-1:0]     seen_next;

	assign cur  = ppc_pkg::fold_char(item.path_char);
	assign span = {window_q, cur};

	// each fragment compared against the newest characters in parallel
	always_comb begin
		for (int f = 0; f < ppc_pkg::FRAG_COUNT; f++) begin
			hits[f] = 1'b1;
			for (int j = 0; j < ppc_pkg::FRAG_MAX; j++) begin
				if (j < int'(ppc_pkg::FRAG_LEN[f]) &&
					span[8*j +: 8] != ppc_pkg::FRAG_TEXT[f][8*j +: 8]) begin
					hits[f] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		kind_eff  = (pos_q == '0) ? item.opcode : kind_q;
		limit     = (kind_eff == ppc_pkg::KIND_REG) ? ppc_pkg::REG_LIMIT : ppc_pkg::IMAGE_LIMIT;
		pos_ext   = {1'b0, pos_q};
		pos_inc   = pos_ext + ppc_pkg::LIMIT_W'(1);
		in_range  = pos_ext < limit;
		active    = !term_q && in_range && (item.path_char != 16'h0000);
		term_next = term_q || (!active) || (pos_inc >= limit);
		seen_next = seen_q | (active ? hits : '0);
		track.kind = term_q ? kind_q : kind_eff;
		track.seen = seen_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			pos_q    <= '0;
			term_q   <= 1'b0;
			kind_q   <= 1'b0;
		end else if (step) begin
			if (item.last) begin
				window_q <= '0;
				seen_q   <= '0;
				pos_q    <= '0;
				term_q   <= 1'b0;
				kind_q   <= 1'b0;
			end else begin
				if (active) begin
					window_q <= span[ppc_pkg::WINDOW_DEPTH*8-1:0];
					pos_q    <= pos_inc[ppc_pkg::POS_W-1:0];
				end
				seen_q <= seen_next;
				term_q <= term_next;
				kind_q <= track.kind;
			end
		end
	end

endmodule

FILE: rtl/ppc_verdict.sv
// prioritized rule table turning seen fragments into one verdict
// depends on ppc_pkg
module ppc_verdict (
	input  ppc_pkg::track_t  track,
	output ppc_pkg::result_t verdict
);

	logic [ppc_pkg::FRAG_COUNT-1:0] s;
	logic [1:0]                     sev;
	logic [2:0]                     rule;

	assign s = track.seen;

	always_comb begin
		sev  = ppc_pkg::SEV_NONE;
		rule = ppc_pkg::RULE_NONE;
		if (track.kind == ppc_pkg::KIND_IMAGE) begin
			if (s[ppc_pkg::F_USERS] || s[ppc_pkg::F_APPDATA] || s[ppc_pkg::F_TEMP]) begin
				sev  = ppc_pkg::SEV_LOW;
				rule = ppc_pkg::RULE_USER_IMAGE;
			end
		end else if (s[ppc_pkg::F_SERVICES] && s[ppc_pkg::F_IMAGEPATH]) begin
			sev  = ppc_pkg::SEV_MED;
			rule = ppc_pkg::RULE_SERVICE;
		end else if (s[ppc_pkg::F_IFEO] && s[ppc_pkg::F_DEBUGGER]) begin
			sev  = ppc_pkg::SEV_HIGH;
			rule = ppc_pkg::RULE_IFEO;
		end else if (s[ppc_pkg::F_WINLOGON] &&
			(s[ppc_pkg::F_SHELL] || s[ppc_pkg::F_USERINIT])) begin
			sev  = ppc_pkg::SEV_HIGH;
			rule = ppc_pkg::RULE_WINLOGON;
		end else if (s[ppc_pkg::F_APPINIT]) begin
			sev  = ppc_pkg::SEV_HIGH;
			rule = ppc_pkg::RULE_APPINIT;
		end else if (s[ppc_pkg::F_RUN]) begin
			sev  = ppc_pkg::SEV_MED;
			rule = ppc_pkg::RULE_AUTORUN;
		end
		verdict.suspicious = (rule != ppc_pkg::RULE_NONE);
		verdict.severity   = sev;
		verdict.rule       = rule;
	end

endmodule

FILE: rtl/path_pattern_classifier_core.sv
// top level of the path pattern classifier: input register, tracker, verdict, result register
// depends on ppc_pkg, ppc_tracker, ppc_verdict
// usage
//   item channel: one path code unit per item (opcode, path_char, last) on
//   item_valid / item_ready. the opcode of the first unit of a path picks
//   image or registry rules; a zero unit or the length limit ends scanning.
//   result channel: exactly one verdict per path, emitted for the unit
//   marked last, on result_valid / result_ready. other units give nothing.
// throughput and pipeline
//   one item per cycle sustained while no last unit waits on a full result
//   register. an item sits in the input register while the window compare and
//   rule table run, and the verdict is registered in the result register when the
//   last unit leaves the input register. the rate is set by the window update loop.
// stalls
//   while a verdict waits in the result register, non-last units keep
//   flowing through the tracker; a last unit holds in the input register
//   until the verdict ahead of it is taken, and item_ready drops with it.
// reset
//   arst_n clears the window, seen flags, position and both valid flags;
//   the block takes items from the first cycle after reset.
module path_pattern_classifier_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ppc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output ppc_pkg::result_t result
);

	// input register
	logic             valid_s1;
	ppc_pkg::item_t   item_s1;

	// result register
	logic             result_valid_q;
	ppc_pkg::result_t result_q;

	logic             advance;
	ppc_pkg::track_t  track;
	ppc_pkg::result_t verdict;

	// a last unit needs a free result slot, any other unit always moves
	assign advance    = valid_s1 && (!item_s1.last || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	ppc_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.track  (track)
	);

	ppc_verdict u_verdict (
		.track   (track),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last) begin
			result_q <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
